[src/kvca_pkg.sv]
// Shared constants, types and helper functions for the KV-cache attention block.
// Depends on nothing; every other file of the block imports it.
package kvca_pkg;

    localparam int LAYERS      = 4;
    localparam int MAX_SEQ_LEN = 256;
    localparam int HEADS       = 4;
    localparam int HEAD_DIM    = 64;

    localparam int ROW_SPAN    = HEADS * HEAD_DIM;
    localparam int LAYER_SPAN  = MAX_SEQ_LEN * ROW_SPAN;
    localparam int STORE_DEPTH = LAYERS * LAYER_SPAN;

    localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int OFF_W  = (LAYER_SPAN > 1) ? $clog2(LAYER_SPAN) : 1;
    localparam int LSEL_W = (LAYERS > 1) ? $clog2(LAYERS) : 1;
    localparam int PIDX_W = (MAX_SEQ_LEN > 1) ? $clog2(MAX_SEQ_LEN) : 1;
    localparam int POS_W  = $clog2(MAX_SEQ_LEN + 1);
    localparam int DIX_W  = (HEAD_DIM > 1) ? $clog2(HEAD_DIM) : 1;

    // Fixed widths of the transaction fields.
    localparam int DATA_W  = 16;
    localparam int ACT_W   = 2;
    localparam int LAYER_W = 2;
    localparam int HEAD_W  = 2;
    localparam int DIM_W   = 6;
    localparam int CNT_W   = 9;

    localparam logic [ACT_W-1:0] ACT_WRITE   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ADVANCE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR   = 2'd2;
    localparam logic [ACT_W-1:0] ACT_QUERY   = 2'd3;

    function automatic longint unsigned isqrt_const(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        longint unsigned x;
        r = 0;
        x = v;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    localparam longint unsigned SCALE = isqrt_const((64'd1 << 32) / HEAD_DIM);
    localparam int SCALE_W = 17;

    localparam int DOT_W   = 2 * DATA_W + $clog2(HEAD_DIM) + 1;
    localparam int SPROD_W = DOT_W + SCALE_W + 1;
    localparam int SCORE_W = 32;
    localparam int W_W     = 17;
    localparam int WSUM_W  = POS_W + 16;
    localparam int ACC_W   = WSUM_W + DATA_W + 1;
    localparam int NUM_W   = ACC_W + 1;
    localparam int NEGD_W  = 23;
    localparam int TPROD_W = NEGD_W + 17;

    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic signed [SCORE_W:0] EXP_FLOOR = -88 * 65536;

    function automatic logic [W_W-1:0] pow2_frac(input logic [3:0] f);
        logic [W_W-1:0] r;
        unique case (f)
            4'd0:  r = 17'd65536;
            4'd1:  r = 17'd62757;
            4'd2:  r = 17'd60097;
            4'd3:  r = 17'd57549;
            4'd4:  r = 17'd55109;
            4'd5:  r = 17'd52773;
            4'd6:  r = 17'd50535;
            4'd7:  r = 17'd48393;
            4'd8:  r = 17'd46341;
            4'd9:  r = 17'd44376;
            4'd10: r = 17'd42495;
            4'd11: r = 17'd40693;
            4'd12: r = 17'd38968;
            4'd13: r = 17'd37316;
            4'd14: r = 17'd35734;
            4'd15: r = 17'd34219;
        endcase
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] store_addr(input logic [LAYER_W-1:0] layer,
                                                     input logic [PIDX_W-1:0] pos,
                                                     input logic [HEAD_W-1:0] head,
                                                     input logic [DIX_W-1:0] d);
        return ADDR_W'(((int'(layer) * MAX_SEQ_LEN + int'(pos)) * HEADS + int'(head))
                       * HEAD_DIM + int'(d));
    endfunction

    typedef struct packed {
        logic                     wr_en;
        logic [ADDR_W-1:0]        wr_addr;
        logic signed [DATA_W-1:0] wr_key;
        logic signed [DATA_W-1:0] wr_val;
        logic [ADDR_W-1:0]        rd_addr;
    } store_req_t;

    typedef struct packed {
        logic              start;
        logic [NUM_W-1:0]  num;
        logic [WSUM_W-1:0] den;
    } div_req_t;

endpackage

[src/kvca_store.sv]
// Key and value stores: two synchronous memories, one write and one read port each.
// Depends on kvca_pkg for the address width and the request struct.
module kvca_store (
    input  logic                            aclk,
    input  kvca_pkg::store_req_t            st_req,
    output logic signed [kvca_pkg::DATA_W-1:0] key_q,
    output logic signed [kvca_pkg::DATA_W-1:0] val_q
);
    import kvca_pkg::*;

    logic signed [DATA_W-1:0] key_mem [STORE_DEPTH];
    logic signed [DATA_W-1:0] val_mem [STORE_DEPTH];
    logic signed [DATA_W-1:0] key_q_reg;
    logic signed [DATA_W-1:0] val_q_reg;

    always_ff @(posedge aclk) begin
        if (st_req.wr_en) begin
            key_mem[st_req.wr_addr] <= st_req.wr_key;
            val_mem[st_req.wr_addr] <= st_req.wr_val;
        end
        key_q_reg <= key_mem[st_req.rd_addr];
        val_q_reg <= val_mem[st_req.rd_addr];
    end

    assign key_q = key_q_reg;
    assign val_q = val_q_reg;

endmodule

[src/kvca_div.sv]
// Restoring divider, one quotient bit per cycle, for the softmax normalisation.
// Depends on kvca_pkg for widths and the request struct.
module kvca_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  kvca_pkg::div_req_t          div_req,
    output logic                        div_done,
    output logic [kvca_pkg::NUM_W-1:0]  div_quo
);
    import kvca_pkg::*;

    localparam int DCNT_W = $clog2(NUM_W);

    logic [NUM_W-1:0]  quo_reg;
    logic [WSUM_W-1:0] rem_reg;
    logic [WSUM_W-1:0] den_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [WSUM_W:0]   trial;

    assign trial = {rem_reg, quo_reg[NUM_W-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (div_req.start) begin
                quo_reg  <= div_req.num;
                rem_reg  <= '0;
                den_reg  <= div_req.den;
                cnt_reg  <= DCNT_W'(NUM_W - 1);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                if (trial >= {1'b0, den_reg}) begin
                    rem_reg <= WSUM_W'(trial - {1'b0, den_reg});
                    quo_reg <= {quo_reg[NUM_W-2:0], 1'b1};
                end else begin
                    rem_reg <= trial[WSUM_W-1:0];
                    quo_reg <= {quo_reg[NUM_W-2:0], 1'b0};
                end
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    assign div_done = done_reg;
    assign div_quo  = quo_reg;

endmodule

[src/kvca_engine.sv]
// Sequencer of the attention block: clearing sweeps, store writes, query buffer,
// score buffer, dot products, exponential weights and the output handshake.
// Depends on kvca_pkg; drives kvca_store and kvca_div through request structs.
module kvca_engine (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [kvca_pkg::ACT_W-1:0]         s_action,
    input  logic [kvca_pkg::LAYER_W-1:0]       s_layer,
    input  logic [kvca_pkg::HEAD_W-1:0]        s_head,
    input  logic [kvca_pkg::DIM_W-1:0]         s_dim_index,
    input  logic signed [kvca_pkg::DATA_W-1:0] s_key_value,
    input  logic signed [kvca_pkg::DATA_W-1:0] s_value_value,
    input  logic signed [kvca_pkg::DATA_W-1:0] s_query_value,
    input  logic [kvca_pkg::CNT_W-1:0]         s_attend_count,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [kvca_pkg::DATA_W-1:0] m_out_value,
    output logic [kvca_pkg::DIM_W-1:0]         m_out_index,
    output logic                               m_last,
    output kvca_pkg::store_req_t               st_req,
    input  logic signed [kvca_pkg::DATA_W-1:0] key_q,
    input  logic signed [kvca_pkg::DATA_W-1:0] val_q,
    output kvca_pkg::div_req_t                 div_req,
    input  logic                               div_done,
    input  logic [kvca_pkg::NUM_W-1:0]         div_quo
);
    import kvca_pkg::*;

    localparam logic [3:0] ST_CLEAR    = 4'd0;
    localparam logic [3:0] ST_IDLE     = 4'd1;
    localparam logic [3:0] ST_DOT_RD   = 4'd2;
    localparam logic [3:0] ST_DOT_END  = 4'd3;
    localparam logic [3:0] ST_SCALE    = 4'd4;
    localparam logic [3:0] ST_SCORE    = 4'd5;
    localparam logic [3:0] ST_W_RD     = 4'd6;
    localparam logic [3:0] ST_W_EXP    = 4'd7;
    localparam logic [3:0] ST_W_WR     = 4'd8;
    localparam logic [3:0] ST_O_RD     = 4'd9;
    localparam logic [3:0] ST_O_END    = 4'd10;
    localparam logic [3:0] ST_DIV_GO   = 4'd11;
    localparam logic [3:0] ST_DIV_WAIT = 4'd12;
    localparam logic [3:0] ST_OUT      = 4'd13;

    localparam logic signed [SPROD_W-1:0] SC_HI = 2147483647;
    localparam logic signed [SPROD_W-1:0] SC_LO = -SC_HI - 1;

    logic [3:0]               state_reg;
    logic [POS_W-1:0]         wp_reg;
    logic [POS_W-1:0]         clr_limit_reg;
    logic [LSEL_W-1:0]        clr_layer_reg;
    logic [OFF_W-1:0]         clr_off_reg;
    logic [LAYER_W-1:0]       layer_reg;
    logic [HEAD_W-1:0]        head_reg;
    logic [POS_W-1:0]         cnt_reg;
    logic [PIDX_W-1:0]        p_reg;
    logic [DIX_W-1:0]         i_reg;
    logic                     zero_mode_reg;
    logic                     rd_vld_reg;
    logic signed [DOT_W-1:0]  dot_reg;
    logic signed [SPROD_W-1:0] sprod_reg;
    logic signed [SCORE_W-1:0] max_reg;
    logic [WSUM_W-1:0]        wsum_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [TPROD_W-1:0]       tprod_reg;
    logic                     wzero_reg;
    logic                     neg_reg;
    logic signed [DATA_W-1:0] res_reg;

    logic signed [DATA_W-1:0]  qbuf [HEAD_DIM];
    logic signed [SCORE_W-1:0] sbuf [MAX_SEQ_LEN];
    logic signed [DATA_W-1:0]  q_q_reg;
    logic signed [SCORE_W-1:0] s_q_reg;

    logic                      accept;
    logic                      where_ok;
    logic                      dim_ok;
    logic                      dim_last;
    logic                      wp_lt_max;
    logic [POS_W-1:0]          cnt_clamp;
    logic                      p_last;
    logic                      i_last;
    logic [OFF_W-1:0]          clr_end;
    logic signed [SCALE_W:0]   scale_s;
    logic signed [SPROD_W-1:0] sprod_sh;
    logic signed [SCORE_W-1:0] score_sat;
    logic signed [SCORE_W:0]   diff;
    logic signed [SCORE_W:0]   negd;
    logic [7:0]                t_n;
    logic [W_W-1:0]            w_val;
    logic signed [2*DATA_W-1:0] qk_prod;
    logic signed [W_W+DATA_W:0] wv_prod;
    logic signed [ACC_W-1:0]   x_acc;
    logic signed [NUM_W-1:0]   x_ext;
    logic                      x_neg;
    logic signed [DATA_W-1:0]  quo_sat;

    assign accept    = (state_reg == ST_IDLE) && s_valid;
    assign where_ok  = (int'(s_layer) < LAYERS) && (int'(s_head) < HEADS);
    assign dim_ok    = int'(s_dim_index) < HEAD_DIM;
    assign dim_last  = int'(s_dim_index) == HEAD_DIM - 1;
    assign wp_lt_max = int'(wp_reg) < MAX_SEQ_LEN;
    assign cnt_clamp = (int'(s_attend_count) > MAX_SEQ_LEN) ? POS_W'(MAX_SEQ_LEN)
                                                            : POS_W'(s_attend_count);
    assign p_last    = POS_W'(p_reg) == cnt_reg - 1'b1;
    assign i_last    = int'(i_reg) == HEAD_DIM - 1;
    assign clr_end   = OFF_W'(int'(clr_limit_reg) * ROW_SPAN - 1);

    // Score: floor(dot * scale / 2^16), saturated to 32 bits.
    assign scale_s  = {1'b0, SCALE_W'(SCALE)};
    assign sprod_sh = sprod_reg >>> 16;
    always_comb begin
        if (sprod_sh > SC_HI) begin
            score_sat = SCORE_W'(SC_HI);
        end else if (sprod_sh < SC_LO) begin
            score_sat = SCORE_W'(SC_LO);
        end else begin
            score_sat = sprod_sh[SCORE_W-1:0];
        end
    end

    // Exponential weight; the base-2 exponent is the product shifted down by 16.
    assign diff = {s_q_reg[SCORE_W-1], s_q_reg} - {max_reg[SCORE_W-1], max_reg};
    assign negd = -diff;
    assign t_n  = tprod_reg[TPROD_W-1:32];
    assign w_val = (wzero_reg || t_n >= 8'd17) ? '0 : (pow2_frac(tprod_reg[31:28]) >> t_n);

    assign qk_prod = q_q_reg * key_q;
    assign wv_prod = $signed({1'b0, s_q_reg[W_W-1:0]}) * val_q;

    // Rounded floor division: negative numerators are biased so that the
    // unsigned quotient equals the magnitude of the floored result.
    assign x_acc = acc_reg + ACC_W'({1'b0, wsum_reg >> 1});
    assign x_ext = NUM_W'(x_acc);
    assign x_neg = x_acc[ACC_W-1];
    always_comb begin
        div_req.start = (state_reg == ST_DIV_GO);
        div_req.den   = wsum_reg;
        if (x_neg) begin
            div_req.num = NUM_W'(-x_ext) + NUM_W'(wsum_reg) - NUM_W'(1);
        end else begin
            div_req.num = NUM_W'(x_ext);
        end
    end

    always_comb begin
        if (!neg_reg) begin
            quo_sat = (div_quo > NUM_W'(32767)) ? DATA_W'(32767) : div_quo[DATA_W-1:0];
        end else begin
            quo_sat = (div_quo > NUM_W'(32768)) ? DATA_W'(32768)
                                                : DATA_W'(-div_quo[DATA_W-1:0]);
        end
    end

    always_comb begin
        st_req         = '0;
        st_req.rd_addr = store_addr(layer_reg, p_reg, head_reg, i_reg);
        if (state_reg == ST_CLEAR) begin
            st_req.wr_en   = 1'b1;
            st_req.wr_addr = ADDR_W'(int'(clr_layer_reg) * LAYER_SPAN) + ADDR_W'(clr_off_reg);
        end else if (accept && s_action == ACT_WRITE && where_ok && dim_ok && wp_lt_max) begin
            st_req.wr_en   = 1'b1;
            st_req.wr_addr = store_addr(s_layer, wp_reg[PIDX_W-1:0], s_head,
                                        s_dim_index[DIX_W-1:0]);
            st_req.wr_key  = s_key_value;
            st_req.wr_val  = s_value_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_action == ACT_QUERY && dim_ok) begin
            qbuf[s_dim_index[DIX_W-1:0]] <= s_query_value;
        end
        q_q_reg <= qbuf[i_reg];
    end

    // The score buffer holds scores first and is then overwritten with weights.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_SCORE) begin
            sbuf[p_reg] <= score_sat;
        end else if (state_reg == ST_W_WR) begin
            sbuf[p_reg] <= SCORE_W'(w_val);
        end
        s_q_reg <= sbuf[p_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            wp_reg        <= '0;
            clr_limit_reg <= POS_W'(MAX_SEQ_LEN);
            clr_layer_reg <= '0;
            clr_off_reg   <= '0;
            rd_vld_reg    <= 1'b0;
            zero_mode_reg <= 1'b0;
            p_reg         <= '0;
            i_reg         <= '0;
        end else begin
            rd_vld_reg <= (state_reg == ST_DOT_RD) || (state_reg == ST_O_RD);
            if (rd_vld_reg && (state_reg == ST_DOT_RD || state_reg == ST_DOT_END)) begin
                dot_reg <= dot_reg + DOT_W'(qk_prod);
            end
            if (rd_vld_reg && (state_reg == ST_O_RD || state_reg == ST_O_END)) begin
                acc_reg <= acc_reg + ACC_W'(wv_prod);
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    if (clr_off_reg == clr_end) begin
                        clr_off_reg <= '0;
                        if (int'(clr_layer_reg) == LAYERS - 1) begin
                            clr_layer_reg <= '0;
                            state_reg     <= ST_IDLE;
                        end else begin
                            clr_layer_reg <= clr_layer_reg + 1'b1;
                        end
                    end else begin
                        clr_off_reg <= clr_off_reg + 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (s_valid) begin
                        unique case (s_action)
                            ACT_WRITE: begin
                            end
                            ACT_ADVANCE: begin
                                if (wp_lt_max) begin
                                    wp_reg <= wp_reg + 1'b1;
                                end
                            end
                            ACT_CLEAR: begin
                                if (wp_reg != '0) begin
                                    clr_limit_reg <= wp_reg;
                                    state_reg     <= ST_CLEAR;
                                end
                                wp_reg <= '0;
                            end
                            ACT_QUERY: begin
                                if (dim_ok && dim_last) begin
                                    layer_reg <= s_layer;
                                    head_reg  <= s_head;
                                    cnt_reg   <= cnt_clamp;
                                    i_reg     <= '0;
                                    p_reg     <= '0;
                                    dot_reg   <= '0;
                                    res_reg   <= '0;
                                    if (!where_ok || cnt_clamp == '0) begin
                                        zero_mode_reg <= 1'b1;
                                        state_reg     <= ST_OUT;
                                    end else begin
                                        zero_mode_reg <= 1'b0;
                                        state_reg     <= ST_DOT_RD;
                                    end
                                end
                            end
                        endcase
                    end
                end
                ST_DOT_RD: begin
                    if (i_last) begin
                        i_reg     <= '0;
                        state_reg <= ST_DOT_END;
                    end else begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                ST_DOT_END: begin
                    state_reg <= ST_SCALE;
                end
                ST_SCALE: begin
                    sprod_reg <= dot_reg * scale_s;
                    state_reg <= ST_SCORE;
                end
                ST_SCORE: begin
                    if (p_reg == '0 || score_sat > max_reg) begin
                        max_reg <= score_sat;
                    end
                    dot_reg <= '0;
                    if (p_last) begin
                        p_reg     <= '0;
                        wsum_reg  <= '0;
                        state_reg <= ST_W_RD;
                    end else begin
                        p_reg     <= p_reg + 1'b1;
                        state_reg <= ST_DOT_RD;
                    end
                end
                ST_W_RD: begin
                    state_reg <= ST_W_EXP;
                end
                ST_W_EXP: begin
                    wzero_reg <= diff < EXP_FLOOR;
                    tprod_reg <= TPROD_W'(negd[NEGD_W-1:0]) * TPROD_W'(LOG2E_Q16);
                    state_reg <= ST_W_WR;
                end
                ST_W_WR: begin
                    wsum_reg <= wsum_reg + WSUM_W'(w_val);
                    if (p_last) begin
                        p_reg     <= '0;
                        i_reg     <= '0;
                        acc_reg   <= '0;
                        state_reg <= ST_O_RD;
                    end else begin
                        p_reg     <= p_reg + 1'b1;
                        state_reg <= ST_W_RD;
                    end
                end
                ST_O_RD: begin
                    if (p_last) begin
                        p_reg     <= '0;
                        state_reg <= ST_O_END;
                    end else begin
                        p_reg <= p_reg + 1'b1;
                    end
                end
                ST_O_END: begin
                    state_reg <= ST_DIV_GO;
                end
                ST_DIV_GO: begin
                    neg_reg   <= x_neg;
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT: begin
                    if (div_done) begin
                        res_reg   <= quo_sat;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (m_ready) begin
                        if (i_last) begin
                            i_reg     <= '0;
                            state_reg <= ST_IDLE;
                        end else begin
                            i_reg <= i_reg + 1'b1;
                            if (!zero_mode_reg) begin
                                acc_reg   <= '0;
                                state_reg <= ST_O_RD;
                            end
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = (state_reg == ST_OUT);
    assign m_out_value = res_reg;
    assign m_out_index = DIM_W'(i_reg);
    assign m_last      = i_last;

endmodule

[src/kv_cache_attention.sv]
// Write, advance and non-final query transactions are accepted in idle and leave it in idle.
// A clear at a nonzero position sweeps LAYERS*position*HEADS*HEAD_DIM store entries, one store entry per cycle.
// A final query element first runs score and weight passes over the count positions,
// then per output element a value pass and the 43-step divider, plus its handshake.
// Reset is synchronous, active low, and starts a pass that zeroes both stores (262144 entries);
// no transaction is accepted during that pass.
module kv_cache_attention (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [kvca_pkg::ACT_W-1:0]         s_action,
    input  logic [kvca_pkg::LAYER_W-1:0]       s_layer,
    input  logic [kvca_pkg::HEAD_W-1:0]        s_head,
    input  logic [kvca_pkg::DIM_W-1:0]         s_dim_index,
    input  logic signed [kvca_pkg::DATA_W-1:0] s_key_value,
    input  logic signed [kvca_pkg::DATA_W-1:0] s_value_value,
    input  logic signed [kvca_pkg::DATA_W-1:0] s_query_value,
    input  logic [kvca_pkg::CNT_W-1:0]         s_attend_count,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [kvca_pkg::DATA_W-1:0] m_out_value,
    output logic [kvca_pkg::DIM_W-1:0]         m_out_index,
    output logic                               m_last
);
    import kvca_pkg::*;

    store_req_t               st_req;
    div_req_t                 div_req;
    logic signed [DATA_W-1:0] key_q;
    logic signed [DATA_W-1:0] val_q;
    logic                     div_done;
    logic [NUM_W-1:0]         div_quo;

    kvca_engine u_engine (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_layer        (s_layer),
        .s_head         (s_head),
        .s_dim_index    (s_dim_index),
        .s_key_value    (s_key_value),
        .s_value_value  (s_value_value),
        .s_query_value  (s_query_value),
        .s_attend_count (s_attend_count),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_value    (m_out_value),
        .m_out_index    (m_out_index),
        .m_last         (m_last),
        .st_req         (st_req),
        .key_q          (key_q),
        .val_q          (val_q),
        .div_req        (div_req),
        .div_done       (div_done),
        .div_quo        (div_quo)
    );

    kvca_store u_store (
        .aclk   (aclk),
        .st_req (st_req),
        .key_q  (key_q),
        .val_q  (val_q)
    );

    kvca_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .div_req  (div_req),
        .div_done (div_done),
        .div_quo  (div_quo)
    );

endmodule

[src/kvca_checker.sv]
// Port-level checks for kv_cache_attention, attached to the top level by a bind.
// Depends on kvca_pkg for field widths.
module kvca_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_ready,
    input logic                               m_valid,
    input logic                               m_ready,
    input logic signed [kvca_pkg::DATA_W-1:0] m_out_value,
    input logic [kvca_pkg::DIM_W-1:0]         m_out_index,
    input logic                               m_last
);
    import kvca_pkg::*;

    // A result waiting for the sink must hold still.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_value) && $stable(m_out_index))
        else $error("result changed while stalled");

    // Input is never taken while a result vector is being delivered.
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready during result delivery");

    // The last flag marks exactly the final element index.
    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_last == (int'(m_out_index) == HEAD_DIM - 1)))
        else $error("last flag does not match element index");

    // After the final result transaction the block returns to accepting input.
    a_back_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last |=> !m_valid && s_ready)
        else $error("block did not return to idle after last result");

endmodule

bind kv_cache_attention kvca_checker u_kvca_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_out_value (m_out_value),
    .m_out_index (m_out_index),
    .m_last      (m_last)
);

[tb/kv_cache_attention_tb.sv]
// Self-checking testbench for the KV-cache attention block.
// Depends on kvca_pkg and kv_cache_attention; it holds its own attention predictor.
module kv_cache_attention_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import kvca_pkg::*;

    localparam longint CYCLE_LIMIT = 6_000_000;
    localparam longint ATTN_SCALE  = 8192;   // floor(sqrt(2^32 / HEAD_DIM)) for HEAD_DIM = 64

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic [DIM_W-1:0]         index;
        logic                     last;
    } attn_out_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [ACT_W-1:0]         s_action = '0;
    logic [LAYER_W-1:0]       s_layer = '0;
    logic [HEAD_W-1:0]        s_head = '0;
    logic [DIM_W-1:0]         s_dim_index = '0;
    logic signed [DATA_W-1:0] s_key_value = '0;
    logic signed [DATA_W-1:0] s_value_value = '0;
    logic signed [DATA_W-1:0] s_query_value = '0;
    logic [CNT_W-1:0]         s_attend_count = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic signed [DATA_W-1:0] m_out_value;
    logic [DIM_W-1:0]         m_out_index;
    logic                     m_last;

    // Predictor state.
    shortint   key_mem [STORE_DEPTH];
    shortint   val_mem [STORE_DEPTH];
    int        cache_pos;
    shortint   query_vec [HEAD_DIM];
    attn_out_t pending_outputs [$];

    int     errors = 0;
    longint cycles = 0;
    int     burst_left = 0;
    int     ready_mode_cnt = 0;
    bit     ready_always = 1'b1;

    kv_cache_attention i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_action(s_action), .s_layer(s_layer), .s_head(s_head),
        .s_dim_index(s_dim_index), .s_key_value(s_key_value),
        .s_value_value(s_value_value), .s_query_value(s_query_value),
        .s_attend_count(s_attend_count),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_out_value(m_out_value), .m_out_index(m_out_index), .m_last(m_last)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int mem_idx(int l, int p, int h, int d);
        return ((l * MAX_SEQ_LEN + p) * HEADS + h) * HEAD_DIM + d;
    endfunction

    function automatic longint floor_quot(longint x, longint s);
        if (x >= 0) return x / s;
        return -((-x + s - 1) / s);
    endfunction

    function automatic longint softmax_weight(longint diff);
        longint t;
        longint n;
        logic [16:0] frac_tab [16] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
                                       46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219};
        if (diff < -88 * 65536) return 0;
        t = (-diff * 94548) >>> 16;
        n = t >>> 16;
        if (n >= 17) return 0;
        return longint'(frac_tab[(t >>> 12) & 15]) >>> n;
    endfunction

    // Scaled dot-product softmax attention over the first cnt positions.
    task automatic predict_attention(int l, int h, int cnt);
        longint scores [MAX_SEQ_LEN];
        longint acc [HEAD_DIM];
        longint top;
        longint wsum;
        longint dot;
        longint w;
        longint o;
        attn_out_t r;
        top = 0;
        wsum = 0;
        for (int i = 0; i < HEAD_DIM; i++) acc[i] = 0;
        for (int p = 0; p < cnt; p++) begin
            dot = 0;
            for (int i = 0; i < HEAD_DIM; i++)
                dot += longint'(query_vec[i]) * longint'(key_mem[mem_idx(l, p, h, i)]);
            dot = (dot * ATTN_SCALE) >>> 16;
            if (dot > 64'sd2147483647) dot = 64'sd2147483647;
            if (dot < -64'sd2147483648) dot = -64'sd2147483648;
            scores[p] = dot;
            if (p == 0 || dot > top) top = dot;
        end
        for (int p = 0; p < cnt; p++) begin
            w = softmax_weight(scores[p] - top);
            wsum += w;
            for (int i = 0; i < HEAD_DIM; i++)
                acc[i] += w * longint'(val_mem[mem_idx(l, p, h, i)]);
        end
        for (int i = 0; i < HEAD_DIM; i++) begin
            o = (cnt == 0) ? 0 : floor_quot(acc[i] + wsum / 2, wsum);
            if (o > 32767) o = 32767;
            if (o < -32768) o = -32768;
            r.value = DATA_W'(o);
            r.index = DIM_W'(i);
            r.last = (i == HEAD_DIM - 1);
            pending_outputs.push_back(r);
        end
    endtask

    task automatic apply_transaction(logic [ACT_W-1:0] act, int l, int h, int d,
                                     shortint k, shortint v, shortint q, int cnt);
        case (act)
            ACT_WRITE: begin
                if (cache_pos < MAX_SEQ_LEN) begin
                    key_mem[mem_idx(l, cache_pos, h, d)] = k;
                    val_mem[mem_idx(l, cache_pos, h, d)] = v;
                end
            end
            ACT_ADVANCE: if (cache_pos < MAX_SEQ_LEN) cache_pos++;
            ACT_CLEAR: begin
                for (int li = 0; li < LAYERS; li++)
                    for (int n = 0; n < cache_pos * ROW_SPAN; n++) begin
                        key_mem[li * LAYER_SPAN + n] = 0;
                        val_mem[li * LAYER_SPAN + n] = 0;
                    end
                cache_pos = 0;
            end
            default: begin
                query_vec[d] = q;
                if (d == HEAD_DIM - 1)
                    predict_attention(l, h, (cnt > MAX_SEQ_LEN) ? MAX_SEQ_LEN : cnt);
            end
        endcase
    endtask

    // Sends one transaction, with bursts and gaps, and updates the predictor on acceptance.
    task automatic send_item(logic [ACT_W-1:0] act, int l, int h, int d,
                             shortint k, shortint v, shortint q, int cnt);
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 8);
        end
        s_valid <= 1'b1;
        s_action <= act;
        s_layer <= LAYER_W'(l);
        s_head <= HEAD_W'(h);
        s_dim_index <= DIM_W'(d);
        s_key_value <= k;
        s_value_value <= v;
        s_query_value <= q;
        s_attend_count <= CNT_W'(cnt);
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
        apply_transaction(act, l, h, d, k, v, q, cnt);
    endtask

    task automatic send_write(int l, int h, int d, shortint k, shortint v);
        send_item(ACT_WRITE, l, h, d, k, v, shortint'($urandom), $urandom_range(0, 511));
    endtask

    task automatic send_query(int l, int h, int d, shortint q, int cnt);
        send_item(ACT_QUERY, l, h, d, shortint'($urandom), shortint'($urandom), q, cnt);
    endtask

    task automatic send_simple(logic [ACT_W-1:0] act);
        send_item(act, $urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 63),
                  shortint'($urandom), shortint'($urandom), shortint'($urandom),
                  $urandom_range(0, 511));
    endtask

    task automatic test_write_extremes();
        send_write(1, 2, 0, 16'sh7fff, -16'sh8000);
        send_write(1, 2, 63, -16'sh8000, 16'sh7fff);
        send_write(3, 3, 5, 16'sh0100, 16'sh0200);
        send_simple(ACT_ADVANCE);
        send_write(1, 2, 0, -16'sh8000, 16'sh7fff);
        send_write(0, 0, 63, 16'sh7fff, 16'sh7fff);
        send_simple(ACT_ADVANCE);
    endtask

    // Every query element is loaded once, so later queries may send the last one alone.
    task automatic test_query_load();
        for (int i = 0; i < HEAD_DIM; i++)
            send_query(1, 2, i, (i % 3 == 0) ? 16'sh7fff : shortint'($urandom), 2);
    endtask

    task automatic test_query_counts();
        send_query(1, 2, HEAD_DIM - 1, -16'sh8000, 0);
        send_query(1, 2, HEAD_DIM - 1, 16'sh0100, 1);
        send_query(3, 3, HEAD_DIM - 1, 16'sh0400, 511);
    endtask

    task automatic test_store_full();
        while (cache_pos < MAX_SEQ_LEN) send_simple(ACT_ADVANCE);
        send_simple(ACT_ADVANCE);
        send_write(2, 1, 7, 16'sh1234, 16'sh4321);
        send_query(2, 1, HEAD_DIM - 1, 16'sh0080, 256);
        send_simple(ACT_CLEAR);
        send_simple(ACT_CLEAR);
        send_query(1, 2, HEAD_DIM - 1, 16'sh0100, 3);
    endtask

    task automatic test_random_traffic();
        int sel;
        int cnt;
        int l;
        int h;
        for (int n = 0; n < 110; n++) begin
            sel = $urandom_range(0, 99);
            l = $urandom_range(0, 1);
            h = $urandom_range(0, 1);
            if (sel < 50) begin
                send_write(l, h, $urandom_range(0, 63), shortint'($urandom),
                           shortint'($urandom));
            end else if (sel < 65) begin
                send_simple(ACT_ADVANCE);
            end else if (sel < 68) begin
                send_simple(ACT_CLEAR);
            end else begin
                if ($urandom_range(0, 19) == 0) cnt = 256 + $urandom_range(0, 255);
                else cnt = $urandom_range(0, cache_pos + 2);
                send_query(l, h, ($urandom_range(0, 2) == 0) ? HEAD_DIM - 1
                                                               : $urandom_range(0, 62),
                           ($urandom_range(0, 3) == 0)
                               ? shortint'($urandom)
                               : shortint'(int'($urandom_range(0, 1023)) - 512),
                           cnt);
            end
        end
    endtask

    // Receiver: stretches of constant readiness alternate with random stalls.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (ready_mode_cnt == 0) begin
            ready_always = ($urandom_range(0, 2) == 0);
            ready_mode_cnt = $urandom_range(50, 400);
        end else begin
            ready_mode_cnt--;
        end
        m_ready <= ready_always || ($urandom_range(0, 3) != 0);
        if (aresetn && m_valid && m_ready) begin
            if (pending_outputs.size() == 0) begin
                $display("%0t: output with none expected: actual value %0d index %0d last %0b",
                         $time, m_out_value, m_out_index, m_last);
                errors++;
            end else begin
                attn_out_t e;
                e = pending_outputs.pop_front();
                if (m_out_value !== e.value || m_out_index !== e.index || m_last !== e.last) begin
                    $display("%0t: mismatch: expected %0d/%0d/%0b, actual %0d/%0d/%0b",
                             $time, e.value, e.index, e.last, m_out_value, m_out_index, m_last);
                    errors++;
                end
            end
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < STORE_DEPTH; i++) begin
            key_mem[i] = 0;
            val_mem[i] = 0;
        end
        for (int i = 0; i < HEAD_DIM; i++) query_vec[i] = 0;
        cache_pos = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_write_extremes();
        test_query_load();
        test_query_counts();
        test_store_full();
        test_random_traffic();
        s_valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

[kv_cache_attention.f]
src/kvca_pkg.sv
src/kvca_store.sv
src/kvca_div.sv
src/kvca_engine.sv
src/kv_cache_attention.sv
src/kvca_checker.sv
tb/kv_cache_attention_tb.sv
